>>> hw/rtl/dltq_pkg.sv
package dltq_pkg;

  // Default sizes
  localparam int unsigned MaxIdsDef    = 16;
  localparam int unsigned DeltaBitsDef = 24;

  // Fixed field widths
  localparam int unsigned IdW     = 4;
  localparam int unsigned IdCount = 16;
  localparam int unsigned TicksW  = 24;

  // Operation codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_EXPIRED   = 3'd0;
  localparam logic [2:0] KIND_INSERTED  = 3'd1;
  localparam logic [2:0] KIND_INS_REJ   = 3'd2;
  localparam logic [2:0] KIND_REMOVED   = 3'd3;
  localparam logic [2:0] KIND_NOT_QUEUED = 3'd4;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IdW-1:0]    waiter_id;
    logic [TicksW-1:0] ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [IdW-1:0]    waiter_id_res;
    logic [TicksW-1:0] delta_left;
    logic              last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_SHU_WR,
    ST_INS_PUT,
    ST_REM_CMP,
    ST_SHD_WR,
    ST_TICK_CMP,
    ST_EXP_CMP,
    ST_EXP_LAST,
    ST_CMP_WR,
    ST_RESP
  } dltq_state_e;

endpackage

>>> hw/rtl/dltq_ram.sv
module dltq_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 28,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/delta_list_timeout_queue.sv
// Delta-list timeout queue: entries are kept in one RAM in expiry order, each holding its
// waiter id and its delta from the entry ahead. One item is processed at a time; the input
// stalls until the item is done, which for a tick can come after its last result has been
// loaded into the output register, and a tick that expires nothing gives no result. RAM
// reads are registered. An insert walks to the slot, then moves later entries up; a remove
// searches for the id, then moves later entries down; a tick counts the head down and, when
// it reaches zero, expires it and the following zero-delta entries, then moves the surviving
// entries to the head. The list holds at most MAX_IDS ids; a stalled output holds the item.
// A result kind of 2 flags a rejected insert, 4 a remove of an id that is not queued.
module delta_list_timeout_queue #(
  parameter int unsigned MAX_IDS    = dltq_pkg::MaxIdsDef,
  parameter int unsigned DELTA_BITS = dltq_pkg::DeltaBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dltq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dltq_pkg::out_item_t out_item_o
);

  localparam int unsigned IW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int unsigned LW = $clog2(MAX_IDS + 1);
  localparam int unsigned DB = DELTA_BITS;
  localparam int unsigned EW = DB + dltq_pkg::IdW;
  localparam logic [DB-1:0] DMax = {DB{1'b1}};

  dltq_pkg::dltq_state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d, pos_q, pos_d, cnt_q, cnt_d, n_q, n_d;
  logic [DB-1:0] t_q, t_d, d_q, d_d;
  logic [dltq_pkg::IdW-1:0] id_q, id_d;
  logic [2:0] kind_q, kind_d;
  logic [dltq_pkg::IdCount-1:0] flags_q, flags_d;
  logic out_valid_q, out_valid_d;
  dltq_pkg::out_item_t out_q, out_d;

  // RAM interface
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, rd_q;
  logic [dltq_pkg::IdW-1:0] rd_id;
  logic [DB-1:0] rd_delta;

  // Helpers
  logic              out_free, emit;
  dltq_pkg::out_item_t emit_item;
  logic [DB-1:0]     t_sat, dec_delta, sum_sat;
  logic [DB:0]       sum_full;
  logic [LW-1:0]     pos_p1, cnt_p1, cnt_p2, cnt_m1, cnt_m2, n_p1, len_m1;
  logic [LW:0]       src_addr;

  dltq_ram #(.Depth(MAX_IDS), .Width(EW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(rd_q)
  );

  assign rd_id    = rd_q[DB +: dltq_pkg::IdW];
  assign rd_delta = rd_q[DB-1:0];

  // Arithmetic helpers
  always_comb begin
    if (DB >= dltq_pkg::TicksW) begin
      t_sat = DB'(in_item_i.ticks);
    end else if (in_item_i.ticks > dltq_pkg::TicksW'(DMax)) begin
      t_sat = DMax;
    end else begin
      t_sat = DB'(in_item_i.ticks);
    end
    dec_delta = (rd_delta == '0) ? '0 : rd_delta - 1'b1;
    sum_full  = {1'b0, rd_delta} + {1'b0, d_q};
    sum_sat   = sum_full[DB] ? DMax : sum_full[DB-1:0];
    pos_p1    = pos_q + 1'b1;
    cnt_p1    = cnt_q + 1'b1;
    cnt_p2    = cnt_q + LW'(2);
    cnt_m1    = cnt_q - 1'b1;
    cnt_m2    = cnt_q - LW'(2);
    n_p1      = n_q + 1'b1;
    len_m1    = len_q - 1'b1;
    src_addr  = {1'b0, cnt_q} + {1'b0, n_q} + 1'b1;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer: next state, RAM accesses and results
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    t_d       = t_q;
    d_d       = d_q;
    id_d      = id_q;
    kind_d    = kind_q;
    flags_d   = flags_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    emit      = 1'b0;
    emit_item = '{kind: kind_q, waiter_id_res: id_q, delta_left: dltq_pkg::TicksW'(d_q),
                  last: 1'b1};

    unique case (state_q)
      dltq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          id_d  = in_item_i.waiter_id;
          t_d   = t_sat;
          pos_d = '0;
          d_d   = '0;
          unique case (in_item_i.mode)
            dltq_pkg::MODE_INSERT: begin
              if (len_q == LW'(MAX_IDS) || flags_q[in_item_i.waiter_id]) begin
                kind_d  = dltq_pkg::KIND_INS_REJ;
                state_d = dltq_pkg::ST_RESP;
              end else if (len_q == '0) begin
                state_d = dltq_pkg::ST_INS_PUT;
              end else begin
                mem_re  = 1'b1;
                state_d = dltq_pkg::ST_INS_CMP;
              end
            end
            dltq_pkg::MODE_REMOVE: begin
              if (!flags_q[in_item_i.waiter_id]) begin
                kind_d  = dltq_pkg::KIND_NOT_QUEUED;
                state_d = dltq_pkg::ST_RESP;
              end else begin
                mem_re  = 1'b1;
                state_d = dltq_pkg::ST_REM_CMP;
              end
            end
            dltq_pkg::MODE_TICK: begin
              if (len_q != '0) begin
                mem_re  = 1'b1;
                state_d = dltq_pkg::ST_TICK_CMP;
              end
            end
            default: ;
          endcase
        end
      end

      // Walk: subtract deltas smaller than the remaining timeout
      dltq_pkg::ST_INS_CMP: begin
        if (rd_delta < t_q) begin
          t_d   = t_q - rd_delta;
          pos_d = pos_p1;
          if (pos_p1 == len_q) begin
            state_d = dltq_pkg::ST_INS_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pos_p1[IW-1:0];
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = len_m1[IW-1:0];
          cnt_d     = len_q;
          state_d   = dltq_pkg::ST_SHU_WR;
        end
      end

      // Move entries up by one; the old slot holder loses the new delta
      dltq_pkg::ST_SHU_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IW-1:0];
        if (cnt_m1 == pos_q) begin
          mem_wdata = {rd_id, rd_delta - t_q};
          state_d   = dltq_pkg::ST_INS_PUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cnt_m2[IW-1:0];
          cnt_d     = cnt_m1;
        end
      end

      dltq_pkg::ST_INS_PUT: begin
        mem_we      = 1'b1;
        mem_waddr   = pos_q[IW-1:0];
        mem_wdata   = {id_q, t_q};
        len_d       = len_q + 1'b1;
        flags_d[id_q] = 1'b1;
        kind_d      = dltq_pkg::KIND_INSERTED;
        state_d     = dltq_pkg::ST_RESP;
      end

      // Search for the id
      dltq_pkg::ST_REM_CMP: begin
        if (rd_id == id_q) begin
          d_d = rd_delta;
          if (pos_p1 == len_q) begin
            len_d         = len_q - 1'b1;
            flags_d[id_q] = 1'b0;
            kind_d        = dltq_pkg::KIND_REMOVED;
            state_d       = dltq_pkg::ST_RESP;
          end else begin
            cnt_d     = pos_q;
            mem_re    = 1'b1;
            mem_raddr = pos_p1[IW-1:0];
            state_d   = dltq_pkg::ST_SHD_WR;
          end
        end else begin
          pos_d     = pos_p1;
          mem_re    = 1'b1;
          mem_raddr = pos_p1[IW-1:0];
        end
      end

      // Move entries down by one; the successor adds the removed delta to its own, saturating
      dltq_pkg::ST_SHD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IW-1:0];
        if (cnt_q == pos_q) begin
          mem_wdata = {rd_id, sum_sat};
        end
        cnt_d = cnt_p1;
        if (cnt_p2 == len_q) begin
          len_d         = len_q - 1'b1;
          flags_d[id_q] = 1'b0;
          kind_d        = dltq_pkg::KIND_REMOVED;
          state_d       = dltq_pkg::ST_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cnt_p2[IW-1:0];
        end
      end

      // Head countdown
      dltq_pkg::ST_TICK_CMP: begin
        if (dec_delta != '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = {rd_id, dec_delta};
          state_d   = dltq_pkg::ST_IDLE;
        end else begin
          id_d           = rd_id;
          flags_d[rd_id] = 1'b0;
          n_d            = LW'(1);
          if (len_q == LW'(1)) begin
            state_d = dltq_pkg::ST_EXP_LAST;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IW'(1);
            state_d   = dltq_pkg::ST_EXP_CMP;
          end
        end
      end

      // Following entries with zero delta expire too
      dltq_pkg::ST_EXP_CMP: begin
        if (rd_delta == '0) begin
          if (out_free) begin
            emit           = 1'b1;
            emit_item      = '{kind: dltq_pkg::KIND_EXPIRED, waiter_id_res: id_q,
                               delta_left: '0, last: 1'b0};
            id_d           = rd_id;
            flags_d[rd_id] = 1'b0;
            n_d            = n_p1;
            if (n_p1 == len_q) begin
              state_d = dltq_pkg::ST_EXP_LAST;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = n_p1[IW-1:0];
            end
          end
        end else begin
          state_d = dltq_pkg::ST_EXP_LAST;
        end
      end

      dltq_pkg::ST_EXP_LAST: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_item = '{kind: dltq_pkg::KIND_EXPIRED, waiter_id_res: id_q,
                        delta_left: '0, last: 1'b1};
          len_d     = len_q - n_q;
          if (n_q == len_q) begin
            state_d = dltq_pkg::ST_IDLE;
          end else begin
            cnt_d     = '0;
            mem_re    = 1'b1;
            mem_raddr = n_q[IW-1:0];
            state_d   = dltq_pkg::ST_CMP_WR;
          end
        end
      end

      // Move survivors to the head
      dltq_pkg::ST_CMP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IW-1:0];
        if (cnt_p1 == len_q) begin
          state_d = dltq_pkg::ST_IDLE;
        end else begin
          cnt_d     = cnt_p1;
          mem_re    = 1'b1;
          mem_raddr = src_addr[IW-1:0];
        end
      end

      dltq_pkg::ST_RESP: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = dltq_pkg::ST_IDLE;
        end
      end

      default: state_d = dltq_pkg::ST_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dltq_pkg::ST_IDLE;
      len_q       <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    cnt_q  <= cnt_d;
    n_q    <= n_d;
    t_q    <= t_d;
    d_q    <= d_d;
    id_q   <= id_d;
    kind_q <= kind_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != dltq_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_IDS))
    else $error("list length above capacity");

  a_flags_match_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dltq_pkg::ST_IDLE |-> $countones(flags_q) == int'(len_q))
    else $error("queued flags disagree with list length");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && out_valid_q |-> !out_stall_i)
    else $error("result loaded over a stalled item");

endmodule
